// ===== rtl/accel_activity_classifier_core_assert.svh =====
// ----------------------------------------------------------------------------
// accel_activity_classifier_core_assert.svh
// assertion macros used by the activity classifier checker
// ----------------------------------------------------------------------------
`ifndef ACCEL_ACTIVITY_CLASSIFIER_CORE_ASSERT_SVH
`define ACCEL_ACTIVITY_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aac_pkg.sv =====
// ----------------------------------------------------------------------------
// aac_pkg
// shared widths, register codes, reset values and types of the classifier
// ----------------------------------------------------------------------------
package aac_pkg;

    localparam int unsigned WINDOW_DEFAULT = 10;

    localparam int unsigned AXIS_W       = 16;
    localparam int unsigned NET_W        = 16;
    localparam int unsigned ONE_G_W      = 15;
    localparam int unsigned LIMIT_W      = 16;
    localparam int unsigned ACT_W        = 2;
    localparam int unsigned SQ_W         = 32;
    localparam int unsigned ROOT_W       = 16;
    localparam int unsigned ROOT_STEPS   = 16;
    localparam int unsigned STEP_CNT_W   = 4;

    localparam int unsigned IN_TDATA_W   = 48;
    localparam int unsigned OUT_FIELDS_W = ACT_W + NET_W;
    localparam int unsigned OUT_TDATA_W  = 24;

    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ONE_G = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WALK  = 2'd2;

    // register reset values
    localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd8192;
    localparam logic [LIMIT_W-1:0] REST_RESET  = 16'd819;
    localparam logic [LIMIT_W-1:0] WALK_RESET  = 16'd4096;

    // activity codes
    localparam logic [ACT_W-1:0] ACT_RESTING = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WALKING = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RUNNING = 2'd2;

    // square root unit status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } isqrt_status_t;

endpackage

// ===== rtl/aac_win_cell.sv =====
// ----------------------------------------------------------------------------
// aac_win_cell
// one entry of the net level window, hands its value to the next cell
// ----------------------------------------------------------------------------
module aac_win_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       shift,
    input  logic [aac_pkg::NET_W-1:0]  din,
    output logic [aac_pkg::NET_W-1:0]  dout
);

    logic [aac_pkg::NET_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

// ===== rtl/aac_isqrt.sv =====
// ----------------------------------------------------------------------------
// aac_isqrt
// floored square root of a 32-bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module aac_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [aac_pkg::SQ_W-1:0]    radicand,
    output aac_pkg::isqrt_status_t      status,
    output logic [aac_pkg::ROOT_W-1:0]  root
);

    logic [aac_pkg::SQ_W-1:0]       rem_reg;
    logic [aac_pkg::SQ_W-1:0]       res_reg;
    logic [aac_pkg::SQ_W-1:0]       bit_reg;
    logic [aac_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [aac_pkg::SQ_W-1:0]       trial;
    logic                           fits;

    assign trial = res_reg + bit_reg;
    assign fits  = (rem_reg >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= aac_pkg::STEP_CNT_W'(aac_pkg::ROOT_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, top pair of bits first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            res_reg <= '0;
            bit_reg <= aac_pkg::SQ_W'(1) << (aac_pkg::SQ_W - 2);
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = res_reg[aac_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/accel_activity_classifier_core.sv =====
// ----------------------------------------------------------------------------
// accel_activity_classifier_core
// a request passes through square (one axis at a time), root, net, window
//   update and classify; no new request is taken until the result is loaded
// the bit-serial square root, one result bit per cycle, sets most of the pace
// reset: registers to defaults, window cells and running total to zero
// ----------------------------------------------------------------------------
module accel_activity_classifier_core #(
    parameter int unsigned WINDOW = aac_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input samples
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [aac_pkg::IN_TDATA_W-1:0]    s_tdata,   // accel_x, accel_y, accel_z
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [aac_pkg::OUT_TDATA_W-1:0]   m_tdata,   // activity, net_level, zero pad
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [aac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aac_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // running total never wraps: WINDOW * 65535 < 2^TOTAL_W
    localparam int unsigned TOTAL_W = aac_pkg::NET_W + $clog2(WINDOW);

    // one-hot sequencer
    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SQUARE   = 5'b00010,
        ST_ROOT     = 5'b00100,
        ST_UPDATE   = 5'b01000,
        ST_CLASSIFY = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [aac_pkg::ONE_G_W-1:0] one_g_reg;
    logic [aac_pkg::LIMIT_W-1:0] rest_limit_reg;
    logic [aac_pkg::LIMIT_W-1:0] walk_limit_reg;

    // sample and arithmetic
    logic signed [aac_pkg::AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [aac_pkg::AXIS_W-1:0] axis_sel;
    logic signed [aac_pkg::SQ_W-1:0]   axis_sq;
    logic [1:0]                        axis_cnt_reg;
    logic [aac_pkg::SQ_W-1:0]          sum_reg, sum_next;
    logic                              sq_last;

    // square root unit
    aac_pkg::isqrt_status_t            sqrt_status;
    logic [aac_pkg::ROOT_W-1:0]        root;
    logic                              sqrt_start;

    // window
    logic [aac_pkg::NET_W-1:0]         net_reg;
    logic [aac_pkg::NET_W-1:0]         net_next;
    logic [aac_pkg::NET_W-1:0]         cell_data [WINDOW];
    logic                              win_shift;
    logic [TOTAL_W-1:0]                total_reg;

    // classification
    logic [TOTAL_W-1:0]                rest_scaled, walk_scaled;
    logic [aac_pkg::ACT_W-1:0]         act;

    // output register
    logic                              out_valid_reg;
    logic [aac_pkg::ACT_W-1:0]         out_act_reg;
    logic [aac_pkg::NET_W-1:0]         out_net_reg;
    logic                              out_load;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    // register writes, unknown index dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_g_reg      <= aac_pkg::ONE_G_RESET;
            rest_limit_reg <= aac_pkg::REST_RESET;
            walk_limit_reg <= aac_pkg::WALK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aac_pkg::REG_ONE_G: one_g_reg      <= cfg_data[aac_pkg::ONE_G_W-1:0];
                aac_pkg::REG_REST:  rest_limit_reg <= cfg_data;
                aac_pkg::REG_WALK:  walk_limit_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // one axis squared per cycle, shared multiplier
    always_comb
    begin
        unique case (axis_cnt_reg)
            2'd0:    axis_sel = ax_reg;
            2'd1:    axis_sel = ay_reg;
            default: axis_sel = az_reg;
        endcase
    end

    assign axis_sq    = aac_pkg::SQ_W'(axis_sel) * aac_pkg::SQ_W'(axis_sel);
    assign sum_next   = sum_reg + aac_pkg::SQ_W'(unsigned'(axis_sq));
    assign sq_last    = (state_reg == ST_SQUARE) && (axis_cnt_reg == 2'd2);
    assign sqrt_start = sq_last;

    aac_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_next),
        .status   (sqrt_status),
        .root     (root)
    );

    // distance of the magnitude from one g
    always_comb
    begin
        if (root >= {1'b0, one_g_reg})
        begin
            net_next = root - {1'b0, one_g_reg};
        end
        else
        begin
            net_next = {1'b0, one_g_reg} - root;
        end
    end

    // window cells, newest in cell 0, oldest falls out of the last cell
    assign win_shift = (state_reg == ST_UPDATE);

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            aac_win_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (win_shift),
                .din   (net_reg),
                .dout  (cell_data[i])
            );
        end
        else
        begin : g_body
            aac_win_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (win_shift),
                .din   (cell_data[i-1]),
                .dout  (cell_data[i])
            );
        end
    end

    // compare total against limit times window, resting tested first
    assign rest_scaled = TOTAL_W'(rest_limit_reg) * TOTAL_W'(WINDOW);
    assign walk_scaled = TOTAL_W'(walk_limit_reg) * TOTAL_W'(WINDOW);

    always_comb
    begin
        priority if (total_reg < rest_scaled)
        begin
            act = aac_pkg::ACT_RESTING;
        end
        else if (total_reg < walk_scaled)
        begin
            act = aac_pkg::ACT_WALKING;
        end
        else
        begin
            act = aac_pkg::ACT_RUNNING;
        end
    end

    assign out_load = (state_reg == ST_CLASSIFY) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (sq_last)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_status.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_cnt_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                axis_cnt_reg <= '0;
            end
            else if (state_reg == ST_SQUARE)
            begin
                axis_cnt_reg <= axis_cnt_reg + 1'b1;
            end
            // drop the oldest entry, add the newest
            if (win_shift)
            begin
                total_reg <= total_reg - TOTAL_W'(cell_data[WINDOW-1]) + TOTAL_W'(net_reg);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ax_reg <= s_tdata[aac_pkg::AXIS_W-1:0];
            ay_reg <= s_tdata[2*aac_pkg::AXIS_W-1:aac_pkg::AXIS_W];
            az_reg <= s_tdata[3*aac_pkg::AXIS_W-1:2*aac_pkg::AXIS_W];
        end
        if (state_reg == ST_IDLE)
        begin
            sum_reg <= '0;
        end
        else if (state_reg == ST_SQUARE)
        begin
            sum_reg <= sum_next;
        end
        if ((state_reg == ST_ROOT) && sqrt_status.done)
        begin
            net_reg <= net_next;
        end
        if (out_load)
        begin
            out_act_reg <= act;
            out_net_reg <= net_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(aac_pkg::OUT_TDATA_W - aac_pkg::OUT_FIELDS_W)'(0),
                       out_net_reg, out_act_reg};

endmodule

// ===== rtl/aac_checker.sv =====
// ----------------------------------------------------------------------------
// aac_checker
// port-level checks of the activity classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "accel_activity_classifier_core_assert.svh"

module aac_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [aac_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // a stalled result keeps its payload
    `AAC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one sample in flight: no request right after a taken one
    `AAC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // activity code is resting, walking or running
    `AAC_ASSERT_NOW(a_act_code, clk, rst_n, m_tvalid, m_tdata[aac_pkg::ACT_W-1:0] != 2'd3, "bad activity code")

    // pad bits above net level stay zero
    `AAC_ASSERT_NOW(a_pad_zero, clk, rst_n, m_tvalid, m_tdata[aac_pkg::OUT_TDATA_W-1:aac_pkg::OUT_FIELDS_W] == '0, "pad bits set")

endmodule

bind accel_activity_classifier_core aac_checker u_aac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
